>>> hw/rtl/locality_sharer_mode_classifier_core_macros.svh
// Assertion macros for the locality sharer mode classifier.
`ifndef LOCALITY_SHARER_MODE_CLASSIFIER_CORE_MACROS_SVH
`define LOCALITY_SHARER_MODE_CLASSIFIER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LSMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LSMC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define LSMC_ASSERT(lbl, prop, msg)

`define LSMC_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> hw/rtl/lsmc_pkg.sv
// Types, constants and helpers shared by the sharer mode classifier.
`timescale 1ns / 1ps

package lsmc_pkg;

    localparam int NUM_SHARERS_DEF = 64;
    localparam logic [7:0] THRESHOLD_RESET = 8'd4;

    localparam logic [1:0] CMD_REQ       = 2'd0;
    localparam logic [1:0] CMD_READ_LOCK = 2'd1;
    localparam logic [1:0] CMD_REPLY     = 2'd2;
    localparam logic [1:0] CMD_QUERY     = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] sender;
        logic       has_requester;
        logic [5:0] requester;
        logic [7:0] reported_util;
    } request_t;

    typedef struct packed {
        logic       sender_mode;
        logic [7:0] sender_utilization;
    } result_t;

    // One table entry: mode bit (1 = remote sharer) and utilization count.
    typedef struct packed {
        logic       mode;
        logic [7:0] util;
    } entry_t;

    function automatic logic [7:0] clamp_count(input logic [8:0] v, input logic [7:0] thr);
        logic [7:0] r;
        if (v >= {1'b0, thr})
            r = thr;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

>>> hw/rtl/lsmc_table.sv
// Sharer table memory with write forwarding and a clearing sweep after reset.
`timescale 1ns / 1ps
`include "locality_sharer_mode_classifier_core_macros.svh"

module lsmc_table #(
    parameter int NUM_SHARERS = lsmc_pkg::NUM_SHARERS_DEF,
    parameter int AW = (NUM_SHARERS > 1) ? $clog2(NUM_SHARERS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output lsmc_pkg::entry_t  rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  lsmc_pkg::entry_t  wr_data,
    output logic              clearing
);
    import lsmc_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SHARERS - 1);

    entry_t        mem [NUM_SHARERS];
    entry_t        mem_q_reg;
    entry_t        byp_reg;
    logic          fwd_reg;
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] clr_addr_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
                clr_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fwd_reg        <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            if (rd_en)
                fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Memory: one write port, one registered read port (old data on collision).
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            mem[clr_addr_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            byp_reg   <= wr_data;
        end
    end

    assign rd_data  = fwd_reg ? byp_reg : mem_q_reg;
    assign clearing = clr_active_reg;

    `LSMC_ASSERT(a_clr_step, clr_active_reg && (clr_addr_reg != LAST_ADDR) |=> clr_active_reg && (clr_addr_reg == $past(clr_addr_reg) + AW'(1)), "clear sweep skipped an entry")
    `LSMC_ASSERT_NEVER(a_wr_during_clr, clr_active_reg && wr_en, "write during clear sweep")
    `LSMC_ASSERT(a_clr_end, clr_active_reg && (clr_addr_reg == LAST_ADDR) |=> !clr_active_reg, "clear sweep did not stop")

endmodule

>>> hw/rtl/locality_sharer_mode_classifier_core.sv
// Top level of the locality-aware sharer mode classifier.
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ----------------------------
//  request   in         start, busy             request (lsmc_pkg::request_t)
//  result    out        done (one-cycle strobe) result  (lsmc_pkg::result_t)
//  config    in         threshold_we            threshold_wdata (8 bits)
//
//  One transaction per cycle while busy is low; the result strobes after
//  s1_valid_reg and done_reg. The rate is set by the table's read-modify-write:
//  registered read at acceptance, update and write back from s1, forwarding
//  into the following read. After reset a sweep clears the table, busy high
//  meanwhile. Threshold writes are taken at any time. Results cannot be stalled.
`timescale 1ns / 1ps
`include "locality_sharer_mode_classifier_core_macros.svh"

module locality_sharer_mode_classifier_core #(
    parameter int NUM_SHARERS = lsmc_pkg::NUM_SHARERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lsmc_pkg::request_t request,
    output logic               done,
    output lsmc_pkg::result_t  result,
    input  logic               threshold_we,
    input  logic [7:0]         threshold_wdata
);
    import lsmc_pkg::*;

    localparam int AW = (NUM_SHARERS > 1) ? $clog2(NUM_SHARERS) : 1;

    logic          accept;
    logic          clearing;
    logic [7:0]    thr_reg;
    logic          s1_valid_reg;
    logic          s1_inrange_reg;
    request_t      s1_req_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_inrange;
    entry_t        cur;
    entry_t        upd;
    logic [8:0]    cnt;
    logic [8:0]    sum;
    logic          hit;
    logic          wr_en;
    logic          done_reg;
    result_t       result_reg;
    result_t       result_next;

    assign accept     = start && !busy;
    assign busy       = clearing;
    assign rd_addr    = AW'(request.sender);
    assign rd_inrange = 32'(request.sender) < 32'(NUM_SHARERS);

    lsmc_table #(
        .NUM_SHARERS (NUM_SHARERS),
        .AW          (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_data  (cur),
        .wr_en    (wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (upd),
        .clearing (clearing)
    );

    // Update of the sender's entry.
    assign cnt = {1'b0, cur.util} + 9'd1;
    assign sum = {1'b0, s1_req_reg.reported_util} + {1'b0, cur.util};
    // Read-lock also hits one below threshold: cnt + 1 >= thr.
    assign hit = (cnt >= {1'b0, thr_reg}) ||
                 ((s1_req_reg.command == CMD_READ_LOCK) &&
                  (({1'b0, cnt} + 10'd1) >= {2'b0, thr_reg}));

    always_comb
    begin
        upd = cur;
        case (s1_req_reg.command)
            CMD_REQ, CMD_READ_LOCK:
            begin
                upd.util = clamp_count(cnt, thr_reg);
                if (cur.mode && hit)
                    upd.mode = 1'b0;
            end
            CMD_REPLY:
            begin
                if (s1_req_reg.has_requester && (s1_req_reg.requester == s1_req_reg.sender))
                    upd.util = clamp_count(sum, thr_reg);
                else
                begin
                    upd.mode = sum < {1'b0, thr_reg};
                    upd.util = '0;
                end
            end
            default:
                upd = cur;
        endcase
    end

    assign wr_en = s1_valid_reg && s1_inrange_reg;

    always_comb
    begin
        result_next = '0;
        if (s1_inrange_reg)
        begin
            result_next.sender_mode        = upd.mode;
            result_next.sender_utilization = upd.util;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= THRESHOLD_RESET;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (threshold_we)
                thr_reg <= threshold_wdata;
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg     <= request;
            s1_addr_reg    <= rd_addr;
            s1_inrange_reg <= rd_inrange;
        end
        if (s1_valid_reg)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `LSMC_ASSERT(a_done_follows, s1_valid_reg |=> done_reg, "result strobe missing")
    `LSMC_ASSERT_NEVER(a_work_in_clear, clearing && s1_valid_reg, "transaction in flight during clear")
    `LSMC_ASSERT(a_oor_zero, s1_valid_reg && !s1_inrange_reg |=> result_reg == '0, "out-of-range sender gave nonzero result")
    `LSMC_ASSERT(a_req_sat, wr_en && ((s1_req_reg.command == CMD_REQ) || (s1_req_reg.command == CMD_READ_LOCK)) |-> upd.util <= thr_reg, "request count above threshold")

endmodule
